### design/sp2uv_pkg.sv
// Package: shared widths, transaction types, arctangent table and turn-to-texture rounding.
`default_nettype none
package sp2uv_pkg;

   localparam int COORD_BITS   = 16;
   localparam int UV_BITS      = 16;
   localparam int CORDIC_STEPS = 28;
   localparam int SQRT_STEPS   = 32;
   localparam int RAD_W        = 64;
   localparam int ROOT_W       = 32;
   localparam int DP_W         = 44;
   localparam int ANG_W        = 34;
   localparam int TURN_W       = 33;
   localparam int U_SHIFT      = 40 - COORD_BITS;
   localparam int V_SHIFT      = 33 - COORD_BITS;
   localparam int UV_SH        = (UV_BITS >= 32) ? 0 : 32 - UV_BITS;
   localparam int UV_RND_SH    = (UV_BITS >= 32) ? 0 : 31 - UV_BITS;
   localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'sd1073741824);
   // input and setup stages, square-root stages, entry, iterations and exit of each CORDIC, output stage
   localparam int PIPE_LAT     = 2 + SQRT_STEPS + CORDIC_STEPS + 2 + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic [UV_BITS-1:0] tex_u;
      logic [UV_BITS-1:0] tex_v;
   } rsp_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         24: v = 32'h00000029;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         default: v = 32'h0;
      endcase
      return ANG_W'($signed({1'b0, v}));
   endfunction

   // Round a turn fraction in [0, 2^32] half up to UV_BITS and saturate.
   function automatic logic [UV_BITS-1:0] turn_to_uv(input logic [TURN_W-1:0] t);
      logic [TURN_W:0] r;
      r = ({1'b0, t} + ((UV_BITS >= 32) ? '0 : ((TURN_W+1)'(1) << UV_RND_SH))) >> UV_SH;
      if (r > (TURN_W+1)'({UV_BITS{1'b1}}))
         return {UV_BITS{1'b1}};
      return r[UV_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

### design/sp2uv_isqrt.sv
// Pipelined floor integer square root, one result bit per stage, with a sideband.
`default_nettype none
module sp2uv_isqrt #(
   parameter int SIDE_W = 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire logic [sp2uv_pkg::RAD_W-1:0]     radicand,
   input  wire logic [SIDE_W-1:0]               in_side,
   output logic                                 out_valid,
   output logic [sp2uv_pkg::ROOT_W-1:0]         root,
   output logic [SIDE_W-1:0]                    out_side
);
   import sp2uv_pkg::*;

   logic [RAD_W-1:0]  n_ff    [1:SQRT_STEPS];
   logic [RAD_W-1:0]  res_ff  [1:SQRT_STEPS];
   logic [SIDE_W-1:0] side_ff [1:SQRT_STEPS];
   logic              vld_ff  [1:SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
      logic [RAD_W-1:0]  n_cur, res_cur, trial, n_in, res_in;
      logic [SIDE_W-1:0] side_cur;
      logic              vld_cur;
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (62 - 2*k);

      if (k == 0) begin : g_first
         assign n_cur    = radicand;
         assign res_cur  = '0;
         assign side_cur = in_side;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign n_cur    = n_ff[k];
         assign res_cur  = res_ff[k];
         assign side_cur = side_ff[k];
         assign vld_cur  = vld_ff[k];
      end

      always_comb begin
         trial = res_cur + BIT;
         if (n_cur >= trial) begin
            n_in   = n_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            n_in   = n_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         n_ff[k+1]    <= n_in;
         res_ff[k+1]  <= res_in;
         side_ff[k+1] <= side_cur;
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_cur;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS];
   assign root      = res_ff[SQRT_STEPS][ROOT_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS];
endmodule
`default_nettype wire

### design/sp2uv_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(yy, xx) for xx >= 0 in binary angle units.
`default_nettype none
module sp2uv_cordic #(
   parameter int SIDE_W = 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic signed [sp2uv_pkg::DP_W-1:0]   xx,
   input  wire logic signed [sp2uv_pkg::DP_W-1:0]   yy,
   input  wire logic [SIDE_W-1:0]                   in_side,
   output logic                                     out_valid,
   output logic signed [sp2uv_pkg::ANG_W-1:0]       angle,
   output logic [SIDE_W-1:0]                        out_side
);
   import sp2uv_pkg::*;

   typedef struct packed {
      logic is_zero;
      logic is_vert;
      logic is_pos;
   } flag_type;

   logic signed [DP_W-1:0]  x_ff    [0:CORDIC_STEPS];
   logic signed [DP_W-1:0]  y_ff    [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0] a_ff    [0:CORDIC_STEPS];
   flag_type                flag_ff [0:CORDIC_STEPS];
   logic [SIDE_W-1:0]       side_ff [0:CORDIC_STEPS];
   logic                    vld_ff  [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0] angle_ff, angle_in;
   logic [SIDE_W-1:0]       oside_ff;
   logic                    ovld_ff;

   // Entry: classify the axes cases, seed the rotation.
   always_ff @(posedge clock) begin
      x_ff[0]            <= xx;
      y_ff[0]            <= yy;
      a_ff[0]            <= '0;
      flag_ff[0].is_zero <= (yy == '0);
      flag_ff[0].is_vert <= (xx == '0);
      flag_ff[0].is_pos  <= !yy[DP_W-1];
      side_ff[0]         <= in_side;
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [DP_W-1:0]  dx, dy, x_in, y_in;
      logic signed [ANG_W-1:0] a_in;
      logic                    up;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         up = !y_ff[i][DP_W-1] && (y_ff[i] != '0);
         if (up) begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            a_in = a_ff[i] + atan_entry(i);
         end else begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            a_in = a_ff[i] - atan_entry(i);
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         a_ff[i+1]    <= a_in;
         flag_ff[i+1] <= flag_ff[i];
         side_ff[i+1] <= side_ff[i];
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   // Exit: resolve axes cases, clamp to a quarter turn.
   always_comb begin
      if (flag_ff[CORDIC_STEPS].is_zero) begin
         angle_in = '0;
      end else if (flag_ff[CORDIC_STEPS].is_vert) begin
         angle_in = flag_ff[CORDIC_STEPS].is_pos ? QUARTER : -QUARTER;
      end else if (a_ff[CORDIC_STEPS] > QUARTER) begin
         angle_in = QUARTER;
      end else if (a_ff[CORDIC_STEPS] < -QUARTER) begin
         angle_in = -QUARTER;
      end else begin
         angle_in = a_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
      oside_ff <= side_ff[CORDIC_STEPS];
      if (reset) begin
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = ovld_ff;
   assign angle     = angle_ff;
   assign out_side  = oside_ff;
endmodule
`default_nettype wire

### design/sphere_point_to_uv_core.sv
// Top level: sphere point to (u, v) texture coordinates, fully pipelined.
//
//  channel   direction  ports                       handshake
//  request   in         start, busy, req_data       accepted when start && !busy
//  response  out        rsp_valid, rsp_data         one-cycle strobe, no back-pressure
//
// One transaction enters per cycle; busy is always low.
// The pipeline holds input and setup stages, 32 square-root stages
// (one root bit each), 30 CORDIC stages (entry, 28 rotations, clamp), output stage.
// Synchronous reset clears all valid bits and drops transactions in flight.
// The response side cannot stall, so the pipeline advances every cycle.
`default_nettype none
module sphere_point_to_uv_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire sp2uv_pkg::req_type req_data,
   output logic                    rsp_valid,
   output sp2uv_pkg::rsp_type      rsp_data
);
   import sp2uv_pkg::*;

   localparam int C       = COORD_BITS;
   localparam int SIDE_SQ = 3*DP_W + 2;

   typedef struct packed {
      logic signed [DP_W-1:0] u_xx;
      logic signed [DP_W-1:0] u_yy;
      logic signed [DP_W-1:0] v_yy;
      logic                   zero_rad;
      logic                   z_pos;
   } sq_side_type;

   // Stage A: capture the request.
   req_type in_ff;
   logic    vld_a_ff;

   always_ff @(posedge clock) begin
      in_ff <= req_data;
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= start && !busy;
      end
   end

   // Stage B: scale operands, clamp y, form 1 - y^2.
   localparam logic signed [C-1:0] ONE    = C'(1) << (C-2);
   localparam logic [RAD_W-1:0]    ONE_SQ = RAD_W'(1) << (2*C-4);

   logic signed [C:0]     abs_z;
   logic signed [C-1:0]   yc;
   logic signed [2*C-1:0] ysq;
   logic [RAD_W-1:0]      rem_in, rem_ff;
   sq_side_type           side_in, side_ff;
   logic                  vld_b_ff;

   always_comb begin
      abs_z = in_ff.point_z[C-1] ? -(C+1)'(in_ff.point_z) : (C+1)'(in_ff.point_z);
      if (in_ff.point_y > ONE) begin
         yc = ONE;
      end else if (in_ff.point_y < -ONE) begin
         yc = -ONE;
      end else begin
         yc = in_ff.point_y;
      end
      ysq              = yc * yc;
      rem_in           = (ONE_SQ - RAD_W'(unsigned'(ysq))) << (2*V_SHIFT);
      side_in.u_xx     = DP_W'(abs_z) <<< U_SHIFT;
      side_in.u_yy     = DP_W'(in_ff.point_x) <<< U_SHIFT;
      side_in.v_yy     = DP_W'(yc) <<< V_SHIFT;
      side_in.zero_rad = (in_ff.point_x == '0) && (in_ff.point_z == '0);
      side_in.z_pos    = !in_ff.point_z[C-1] && (in_ff.point_z != '0);
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      side_ff <= side_in;
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else begin
         vld_b_ff <= vld_a_ff;
      end
   end

   // sqrt(1 - y^2); the longitude operands ride along as sideband.
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sq_side_type       sq_side;

   sp2uv_isqrt #(.SIDE_W(SIDE_SQ)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_b_ff),
      .radicand  (rem_ff),
      .in_side   (side_ff),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   // Longitude arctangent and latitude arcsine run side by side.
   logic                    u_valid, v_valid, u_zpos, v_zero;
   logic signed [ANG_W-1:0] u_ang, v_ang;

   sp2uv_cordic #(.SIDE_W(1)) u_cordic_u (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .xx        (sq_side.u_xx),
      .yy        (sq_side.u_yy),
      .in_side   (sq_side.z_pos),
      .out_valid (u_valid),
      .angle     (u_ang),
      .out_side  (u_zpos)
   );

   sp2uv_cordic #(.SIDE_W(1)) u_cordic_v (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .xx        (DP_W'(sq_root)),
      .yy        (sq_side.v_yy),
      .in_side   (sq_side.zero_rad),
      .out_valid (v_valid),
      .angle     (v_ang),
      .out_side  (v_zero)
   );

   // Output stage: offset, mirror for z > 0, round and saturate; zero radius gives zero.
   logic [TURN_W-1:0] tu, tv;
   rsp_type           rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      tu = TURN_W'(u_ang + QUARTER);
      if (u_zpos) begin
         tu = (TURN_W'(1) << 32) - tu;
      end
      tv = TURN_W'((v_ang <<< 1) + (QUARTER <<< 1));
      if (v_zero) begin
         rsp_in = '0;
      end else begin
         rsp_in.tex_u = turn_to_uv(tu);
         rsp_in.tex_v = turn_to_uv(tv);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= u_valid && v_valid;
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

### design/sp2uv_checker.sv
// Checker: port-level never-busy, latency, no-spurious-response and zero-radius properties, bound to the top level.
`default_nettype none
module sp2uv_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire sp2uv_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire sp2uv_pkg::rsp_type rsp_data
);
   import sp2uv_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("response missing after accepted transaction");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !$past(start && !busy, PIPE_LAT) |-> !rsp_valid)
      else $error("response without transaction");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.point_x == '0 && req_data.point_z == '0)
      |-> ##PIPE_LAT (rsp_data == '0))
      else $error("zero radius must give zero coordinates");
endmodule

bind sphere_point_to_uv_core sp2uv_checker u_sp2uv_checker (.*);
`default_nettype wire

### tb/tb_top.sv
// Testbench for sphere_point_to_uv_core: checks texture coordinates against a CORDIC predictor.
`default_nettype none

class uv_scoreboard;
   sp2uv_pkg::rsp_type pending_uv[$];
   int mismatch_count;

   // Arithmetic shift right rounding toward minus infinity.
   static function longint asr_floor(longint v, int s);
      return v >>> s;
   endfunction

   static function longint cordic_angle(longint xx, longint yy);
      longint ang, dx, dy, tab;
      ang = 0;
      if (yy == 0) return 0;
      if (xx == 0) return (yy > 0) ? 64'sd1073741824 : -64'sd1073741824;
      for (int i = 0; i < sp2uv_pkg::CORDIC_STEPS; i++) begin
         dx = asr_floor(yy, i);
         dy = asr_floor(xx, i);
         tab = longint'(sp2uv_pkg::atan_entry(i));
         if (yy > 0) begin
            xx += dx; yy -= dy; ang += tab;
         end else begin
            xx -= dx; yy += dy; ang -= tab;
         end
      end
      if (ang > 64'sd1073741824) ang = 64'sd1073741824;
      if (ang < -64'sd1073741824) ang = -64'sd1073741824;
      return ang;
   endfunction

   static function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   static function logic [15:0] round_turn(longint unsigned t);
      longint unsigned r;
      r = (t + (64'd1 << (31 - sp2uv_pkg::UV_BITS))) >> (32 - sp2uv_pkg::UV_BITS);
      if (r > 64'hFFFF) r = 64'hFFFF;
      return r[15:0];
   endfunction

   static function sp2uv_pkg::rsp_type map_point(sp2uv_pkg::req_type p);
      sp2uv_pkg::rsp_type o;
      longint px, py, pz, ang, yc, one;
      longint unsigned tu, tv, rem;
      px = p.point_x; py = p.point_y; pz = p.point_z;
      one = 64'sd1 << (sp2uv_pkg::COORD_BITS - 2);
      o = '0;
      if (px == 0 && pz == 0) return o;
      ang = cordic_angle(((pz < 0) ? -pz : pz) <<< 24, px <<< 24);
      tu = ang + 64'sd1073741824;
      if (pz > 0) tu = (64'd1 << 32) - tu;
      yc = py;
      if (yc > one) yc = one;
      if (yc < -one) yc = -one;
      rem = (one * one - yc * yc) << 34;
      ang = cordic_angle(longint'(floor_sqrt(rem)), yc <<< 17);
      tv = 2 * ang + 2 * 64'sd1073741824;
      o.tex_u = round_turn(tu);
      o.tex_v = round_turn(tv);
      return o;
   endfunction

   function void note_point(sp2uv_pkg::req_type p);
      pending_uv.push_back(map_point(p));
   endfunction

   function void check_uv(sp2uv_pkg::rsp_type got);
      sp2uv_pkg::rsp_type want;
      if (pending_uv.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result u=%0d v=%0d", got.tex_u, got.tex_v);
         return;
      end
      want = pending_uv.pop_front();
      if (got.tex_u !== want.tex_u || got.tex_v !== want.tex_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected u=%0d v=%0d, got u=%0d v=%0d",
                     want.tex_u, want.tex_v, got.tex_u, got.tex_v);
      end
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   sp2uv_pkg::req_type req_data;
   logic               rsp_valid;
   sp2uv_pkg::rsp_type rsp_data;

   uv_scoreboard board;

   sphere_point_to_uv_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far above 1150 items with gaps plus pipeline latency.
   initial begin
      #2ms;
      $display("tb_top: errors");
      $finish;
   end

   // Sample both channels at the rising edge; note each accepted transaction
   // before checking so an item and its result never race.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_point(req_data);
         if (rsp_valid) board.check_uv(rsp_data);
      end
   end

   // Drive one transaction; hold start until the block takes it.
   task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      start <= 1'b1;
      req_data <= '{point_x: x, point_y: y, point_z: z};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic go_idle(input int cycles);
      start <= 1'b0;
      req_data <= '0;
      repeat (cycles) @(negedge clock);
   endtask

   // Mostly coordinates within the unit range, some anywhere in the field range, some near zero.
   function automatic logic [15:0] pick_coord(input int kind);
      case (kind)
         0: return 16'($urandom_range(0, 32768) - 16384);
         1: return 16'($urandom);
         default: return 16'($urandom_range(0, 40) - 20);
      endcase
   endfunction

   initial begin
      int burst, kind;
      logic [15:0] corner[8];
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero radius, axis points, clamped y, field extremes.
      corner = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h2D41};
      send_point(16'h0000, 16'h1234, 16'h0000);
      send_point(16'h0000, 16'h7FFF, 16'h0000);
      send_point(16'h0000, 16'h0000, 16'h4000);
      send_point(16'h0000, 16'h0000, 16'hC000);
      send_point(16'h4000, 16'h0000, 16'h0000);
      send_point(16'hC000, 16'h0000, 16'h0000);
      send_point(16'h2D41, 16'h4000, 16'h2D41);
      send_point(16'h2D41, 16'hC000, 16'hD2BF);
      send_point(16'h1000, 16'h7FFF, 16'h1000);
      send_point(16'h1000, 16'h8000, 16'hF000);
      for (int i = 0; i < 8; i++) send_point(corner[i], corner[7 - i], corner[(i + 3) % 8]);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000, 16'h8000);

      // Drain completely once before the random part.
      go_idle(1);
      while (board.pending_uv.size() != 0) @(negedge clock);

      for (int n = 0; n < 1150; n += burst) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst; b++) begin
            kind = ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 1) != 0) ? 1 : 2);
            send_point(pick_coord(kind), pick_coord(kind), pick_coord(kind));
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
      end

      go_idle(1);
      while (board.pending_uv.size() != 0) @(negedge clock);
      repeat (sp2uv_pkg::PIPE_LAT + 10) @(negedge clock);
      if (board.mismatch_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule

`default_nettype wire

### files.f
design/sp2uv_pkg.sv
design/sp2uv_isqrt.sv
design/sp2uv_cordic.sv
design/sphere_point_to_uv_core.sv
design/sp2uv_checker.sv
tb/tb_top.sv
